@@ design/ugb_pkg.sv @@
// Shared codes, field widths and parameter defaults for the uniform grid broadphase.
// No dependencies; used by uniform_grid_broadphase.
package ugb_pkg;

    localparam int GRID_SIDE_MAX_DEF  = 32;
    localparam int CELL_CAPACITY_DEF  = 8;
    localparam int CELL_SIZE_LOG2_DEF = 12;
    localparam int ENTITY_BITS_DEF    = 16;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 16;
    localparam int POS_W    = 20;
    localparam int EXT_W    = 19;
    localparam int KIND_W   = 2;
    localparam int CFG_W    = 6;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PAIRS  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_OK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ITEM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd3;

    localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 6'd32;

endpackage

@@ design/uniform_grid_broadphase.sv @@
// Top level of the uniform grid broadphase: command decode, walk sequencer, output register.
// Depends on ugb_pkg and ugb_ram (cell count memory and cell entry memory).
//
// Channel | Dir | Handshake                  | Payload
// s_      | in  | s_tvalid / s_tready        | s_tdata (entity, position, extents), s_tuser (func)
// m_      | out | m_tvalid / m_tready        | m_tdata (first, second entity), m_tuser (kind)
// cfg_    | in  | cfg_valid / cfg_ready      | cfg_data (grid_side)
//
// One transaction is worked at a time. Insert reads the cell count and then writes the
// count and entry before the output register; starts only set up the walk; clear zeroes
// every cell count. A next transaction reads the count of each cell it passes (query), or
// of each cell and of the neighbor in each neighbor phase (pair scan), before fetching
// entries through the single read port of each memory.
// After reset a clearing pass zeroes the cell counts; s_tready stays low during it. A
// stalled result holds in the output register while the next transaction is taken, and
// that transaction waits to deliver until the register frees.
module uniform_grid_broadphase #(
    parameter int GRID_SIDE_MAX  = ugb_pkg::GRID_SIDE_MAX_DEF,
    parameter int CELL_CAPACITY  = ugb_pkg::CELL_CAPACITY_DEF,
    parameter int CELL_SIZE_LOG2 = ugb_pkg::CELL_SIZE_LOG2_DEF,
    parameter int ENTITY_BITS    = ugb_pkg::ENTITY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entity_id[15:0], pos_x[35:16], pos_y[55:36], body_radius[74:56],
    // half_width[93:75], half_height[112:94], zero fill above
    input  logic [ugb_pkg::S_DATA_W-1:0]  s_tdata,
    // func[2:0]
    input  logic [ugb_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // first_entity[15:0], second_entity[31:16]
    output logic [ugb_pkg::M_DATA_W-1:0]  m_tdata,
    // result_kind[1:0]
    output logic [ugb_pkg::KIND_W-1:0]    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ugb_pkg::CFG_W-1:0]     cfg_data
);
    localparam int NCELLS = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int IDXW   = $clog2(GRID_SIDE_MAX);
    localparam int SW     = $clog2(GRID_SIDE_MAX + 1);
    localparam int XW     = (SW > ugb_pkg::CFG_W) ? SW : ugb_pkg::CFG_W;
    localparam int CADW   = $clog2(NCELLS);
    localparam int EADW   = $clog2(NCELLS * CELL_CAPACITY);
    localparam int CW     = $clog2(CELL_CAPACITY + 1);
    localparam int SLW    = $clog2(CELL_CAPACITY + 2);
    localparam int HIW    = SW + CELL_SIZE_LOG2;
    localparam int AW     = ((HIW > ugb_pkg::POS_W + 1) ? HIW : ugb_pkg::POS_W + 1) + 2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_INS_RD, S_INS_WR,
        S_QCHK, S_QCNT, S_QENT,
        S_PCHK, S_PCNT, S_PPH, S_PNC, S_PE1, S_PE2, S_EMIT
    } state_t;

    typedef enum logic [1:0] {MODE_IDLE, MODE_QUERY, MODE_PAIRS} mode_t;

    typedef struct packed {
        logic [ugb_pkg::KIND_W-1:0] kind;
        logic [ugb_pkg::ID_W-1:0]   first;
        logic [ugb_pkg::ID_W-1:0]   second;
    } result_t;

    // ---------------- registers ----------------
    state_t                       state_reg, state_next;
    mode_t                        mode_reg, mode_next;
    logic                         clr_ret_reg, clr_ret_next;   // clear command, not reset pass
    logic [CADW-1:0]              clr_addr_reg, clr_addr_next;
    logic [ugb_pkg::CFG_W-1:0]    grid_side_reg;
    logic                         m_valid_reg, m_valid_next;
    result_t                      m_res_reg, m_res_next;
    result_t                      res_reg, res_next;           // result waiting for output
    logic [ugb_pkg::FUNC_W-1:0]   func_reg;
    logic [ugb_pkg::ID_W-1:0]     id_reg;
    logic signed [ugb_pkg::POS_W-1:0] px_reg, py_reg;
    logic [ugb_pkg::EXT_W-1:0]    r_reg, hw_reg, hh_reg;
    logic [CADW-1:0]              cell_reg, cell_next;
    logic [CADW-1:0]              nbr_reg, nbr_next;
    logic [SW-1:0]                cx_reg, cx_next, cy_reg, cy_next;
    logic [IDXW-1:0]              sx_reg, sx_next, sy_reg, sy_next;
    logic [IDXW-1:0]              ex_reg, ex_next, ey_reg, ey_next;
    logic [SLW-1:0]               os_reg, os_next, is_reg, is_next;
    logic [2:0]                   ph_reg, ph_next;
    logic [CW-1:0]                own_cnt_reg, own_cnt_next;
    logic [ugb_pkg::ID_W-1:0]     e1_reg, e1_next;

    // ---------------- memories ----------------
    logic                   cnt_we;
    logic [CADW-1:0]        cnt_waddr, cnt_raddr;
    logic [CW-1:0]          cnt_wdata, cnt_rdata;
    logic                   ent_we;
    logic [EADW-1:0]        ent_waddr, ent_raddr;
    logic [ENTITY_BITS-1:0] ent_wdata, ent_rdata;

    ugb_ram #(.WIDTH(CW), .DEPTH(NCELLS)) u_count_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    ugb_ram #(.WIDTH(ENTITY_BITS), .DEPTH(NCELLS * CELL_CAPACITY)) u_entry_ram (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    // ---------------- helpers ----------------
    function automatic logic [CADW-1:0] cell_addr(input logic [SW-1:0] x,
                                                  input logic [SW-1:0] y);
        return CADW'(x) * CADW'(GRID_SIDE_MAX) + CADW'(y);
    endfunction

    function automatic logic [EADW-1:0] slot_addr(input logic [CADW-1:0] c,
                                                  input logic [SLW-1:0] s);
        return EADW'(c) * EADW'(CELL_CAPACITY) + EADW'(s);
    endfunction

    // floor(v / cell), zero when negative, saturated to side-1
    function automatic logic [IDXW-1:0] to_index(input logic signed [AW-1:0] v,
                                                 input logic [SW-1:0] sd);
        logic [AW-1:0] q;
        logic [AW-1:0] lim;
        q   = AW'($unsigned(v)) >> CELL_SIZE_LOG2;
        lim = AW'(sd) - AW'(1);
        if (v[AW-1]) begin
            return '0;
        end else if (q > lim) begin
            return IDXW'(lim);
        end
        return IDXW'(q);
    endfunction

    // effective side: zero acts as one, large values saturate
    logic [SW-1:0] side;
    always_comb begin
        if (grid_side_reg == '0) begin
            side = SW'(1);
        end else if (XW'(grid_side_reg) > XW'(GRID_SIDE_MAX)) begin
            side = SW'(GRID_SIDE_MAX);
        end else begin
            side = SW'(grid_side_reg);
        end
    end

    // position arithmetic for insert and query start
    logic signed [AW-1:0] pxs, pys, rs, hws, hhs, cell_sz, hi, ix, iy;
    always_comb begin
        pxs     = AW'(px_reg);
        pys     = AW'(py_reg);
        rs      = $signed(AW'(r_reg));
        hws     = $signed(AW'(hw_reg));
        hhs     = $signed(AW'(hh_reg));
        cell_sz = $signed(AW'(1) << CELL_SIZE_LOG2);
        hi      = $signed(AW'(side) << CELL_SIZE_LOG2) - rs;
        ix      = (pxs < rs) ? rs : pxs;
        iy      = (pys < rs) ? rs : pys;
        if (ix > hi) begin
            ix = hi;
        end
        if (iy > hi) begin
            iy = hi;
        end
    end

    // neighbor selection for the pair walk
    logic          nb_ok;
    logic [SW-1:0] nb_x, nb_y;
    always_comb begin
        nb_x  = cx_reg;
        nb_y  = cy_reg;
        nb_ok = 1'b1;
        case (ph_reg)
            3'd0: begin
                nb_ok = 1'b1;
            end
            3'd1: begin
                nb_ok = (cx_reg != '0);
                nb_x  = cx_reg - SW'(1);
            end
            3'd2: begin
                nb_ok = (cx_reg != '0) && (cy_reg != '0);
                nb_x  = cx_reg - SW'(1);
                nb_y  = cy_reg - SW'(1);
            end
            3'd3: begin
                nb_ok = (cy_reg != '0);
                nb_y  = cy_reg - SW'(1);
            end
            default: begin
                nb_ok = (cy_reg != '0) && ((XW'(cx_reg) + XW'(1)) < XW'(side));
                nb_x  = cx_reg + SW'(1);
                nb_y  = cy_reg - SW'(1);
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        clr_ret_next = clr_ret_reg;
        clr_addr_next = clr_addr_reg;
        res_next     = res_reg;
        cell_next    = cell_reg;
        nbr_next     = nbr_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        os_next      = os_reg;
        is_next      = is_reg;
        ph_next      = ph_reg;
        own_cnt_next = own_cnt_reg;
        e1_next      = e1_reg;
        cnt_we       = 1'b0;
        cnt_waddr    = cell_reg;
        cnt_wdata    = '0;
        cnt_raddr    = cell_reg;
        ent_we       = 1'b0;
        ent_waddr    = slot_addr(cell_reg, SLW'(cnt_rdata));
        ent_wdata    = ENTITY_BITS'(id_reg);
        ent_raddr    = slot_addr(cell_reg, os_reg);

        // drain the output register
        m_valid_next = m_valid_reg && !m_tready;
        m_res_next   = m_res_reg;

        unique case (state_reg)
            S_CLR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + CADW'(1);
                if (clr_addr_reg == CADW'(NCELLS - 1)) begin
                    clr_addr_next = '0;
                    if (clr_ret_reg) begin
                        res_next   = '{ugb_pkg::KIND_OK, '0, '0};
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                res_next   = '{ugb_pkg::KIND_OK, '0, '0};
                state_next = S_EMIT;
                unique case (func_reg)
                    ugb_pkg::FUNC_INSERT: begin
                        cell_next  = cell_addr(SW'(to_index(ix, side)), SW'(to_index(iy, side)));
                        state_next = S_INS_RD;
                    end
                    ugb_pkg::FUNC_QUERY: begin
                        sx_next   = to_index(pxs - hws - cell_sz, side);
                        sy_next   = to_index(pys - hhs - cell_sz, side);
                        ex_next   = to_index(pxs + hws + cell_sz, side);
                        ey_next   = to_index(pys + hhs + cell_sz, side);
                        cx_next   = SW'(to_index(pxs - hws - cell_sz, side));
                        cy_next   = SW'(to_index(pys - hhs - cell_sz, side));
                        os_next   = '0;
                        ph_next   = '0;
                        is_next   = '0;
                        mode_next = MODE_QUERY;
                    end
                    ugb_pkg::FUNC_PAIRS: begin
                        cx_next   = '0;
                        cy_next   = '0;
                        os_next   = '0;
                        ph_next   = '0;
                        is_next   = SLW'(1);
                        mode_next = MODE_PAIRS;
                    end
                    ugb_pkg::FUNC_NEXT: begin
                        unique case (mode_reg)
                            MODE_QUERY: state_next = S_QCHK;
                            MODE_PAIRS: state_next = S_PCHK;
                            default:    res_next = '{ugb_pkg::KIND_END, '0, '0};
                        endcase
                    end
                    ugb_pkg::FUNC_CLEAR: begin
                        clr_ret_next = 1'b1;
                        state_next   = S_CLR;
                    end
                    default: begin
                        res_next = '{ugb_pkg::KIND_OK, '0, '0};
                    end
                endcase
            end
            S_INS_RD: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                // cnt_rdata holds the live count of the target cell
                if (SLW'(cnt_rdata) >= SLW'(CELL_CAPACITY)) begin
                    res_next = '{ugb_pkg::KIND_FULL, id_reg, '0};
                end else begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + CW'(1);
                    ent_we    = 1'b1;
                    res_next  = '{ugb_pkg::KIND_OK, id_reg, '0};
                end
                state_next = S_EMIT;
            end
            // ---- query walk: y outer, x inner ----
            S_QCHK: begin
                if (cy_reg > SW'(ey_reg)) begin
                    mode_next  = MODE_IDLE;
                    res_next   = '{ugb_pkg::KIND_END, '0, '0};
                    state_next = S_EMIT;
                end else if (cx_reg > SW'(ex_reg)) begin
                    cx_next = SW'(sx_reg);
                    cy_next = cy_reg + SW'(1);
                    os_next = '0;
                end else begin
                    cell_next  = cell_addr(cx_reg, cy_reg);
                    cnt_raddr  = cell_addr(cx_reg, cy_reg);
                    state_next = S_QCNT;
                end
            end
            S_QCNT: begin
                if (os_reg < SLW'(cnt_rdata)) begin
                    ent_raddr  = slot_addr(cell_reg, os_reg);
                    os_next    = os_reg + SLW'(1);
                    state_next = S_QENT;
                end else begin
                    cx_next    = cx_reg + SW'(1);
                    os_next    = '0;
                    state_next = S_QCHK;
                end
            end
            S_QENT: begin
                res_next   = '{ugb_pkg::KIND_ITEM, ugb_pkg::ID_W'(ent_rdata), '0};
                state_next = S_EMIT;
            end
            // ---- pair walk: x outer, y inner, then slots and neighbor phases ----
            S_PCHK: begin
                if (cx_reg >= side) begin
                    mode_next  = MODE_IDLE;
                    res_next   = '{ugb_pkg::KIND_END, '0, '0};
                    state_next = S_EMIT;
                end else if (cy_reg >= side) begin
                    cx_next = cx_reg + SW'(1);
                    cy_next = '0;
                    os_next = '0;
                    ph_next = '0;
                    is_next = SLW'(1);
                end else begin
                    cell_next  = cell_addr(cx_reg, cy_reg);
                    cnt_raddr  = cell_addr(cx_reg, cy_reg);
                    state_next = S_PCNT;
                end
            end
            S_PCNT: begin
                own_cnt_next = cnt_rdata;
                state_next   = S_PPH;
            end
            S_PPH: begin
                if (os_reg >= SLW'(own_cnt_reg)) begin
                    cy_next    = cy_reg + SW'(1);
                    os_next    = '0;
                    ph_next    = '0;
                    is_next    = SLW'(1);
                    state_next = S_PCHK;
                end else if (ph_reg > 3'd4) begin
                    os_next = os_reg + SLW'(1);
                    ph_next = '0;
                    is_next = os_reg + SLW'(2);
                end else if (!nb_ok) begin
                    ph_next = ph_reg + 3'd1;
                    is_next = '0;
                end else begin
                    nbr_next   = cell_addr(nb_x, nb_y);
                    cnt_raddr  = cell_addr(nb_x, nb_y);
                    state_next = S_PNC;
                end
            end
            S_PNC: begin
                if (is_reg < SLW'(cnt_rdata)) begin
                    ent_raddr  = slot_addr(cell_reg, os_reg);
                    state_next = S_PE1;
                end else begin
                    ph_next    = ph_reg + 3'd1;
                    is_next    = '0;
                    state_next = S_PPH;
                end
            end
            S_PE1: begin
                e1_next    = ugb_pkg::ID_W'(ent_rdata);
                ent_raddr  = slot_addr(nbr_reg, is_reg);
                state_next = S_PE2;
            end
            S_PE2: begin
                res_next   = '{ugb_pkg::KIND_ITEM, e1_reg, ugb_pkg::ID_W'(ent_rdata)};
                is_next    = is_reg + SLW'(1);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            mode_reg      <= MODE_IDLE;
            clr_ret_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            grid_side_reg <= ugb_pkg::GRID_SIDE_RESET;
            m_valid_reg   <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            ex_reg        <= '0;
            ey_reg        <= '0;
            os_reg        <= '0;
            is_reg        <= '0;
            ph_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            clr_ret_reg  <= (state_reg == S_CLR && state_next != S_CLR) ? 1'b0 : clr_ret_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_valid) begin
                grid_side_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            os_reg      <= os_next;
            is_reg      <= is_next;
            ph_reg      <= ph_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg <= s_tuser;
            id_reg   <= s_tdata[15:0];
            px_reg   <= s_tdata[35:16];
            py_reg   <= s_tdata[55:36];
            r_reg    <= s_tdata[74:56];
            hw_reg   <= s_tdata[93:75];
            hh_reg   <= s_tdata[112:94];
        end
        m_res_reg   <= m_res_next;
        res_reg     <= res_next;
        cell_reg    <= cell_next;
        nbr_reg     <= nbr_next;
        own_cnt_reg <= own_cnt_next;
        e1_reg      <= e1_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_res_reg.kind;
    assign m_tdata   = {m_res_reg.second, m_res_reg.first};

    // ---------------- assertions ----------------
    // one transaction at a time: nothing more is taken the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // end markers never carry an entity; dropped inserts carry no partner but are not checked
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ugb_pkg::KIND_END)) |-> (m_tdata == '0))
        else $error("end marker with nonzero entities");

    // a stored count never exceeds the cell capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (SLW'(cnt_wdata) <= SLW'(CELL_CAPACITY)))
        else $error("cell count written above capacity");

    // a result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_tready) |=> (state_reg == S_EMIT))
        else $error("pending result overwritten");

endmodule

@@ design/ugb_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; instantiated twice by uniform_grid_broadphase.
module ugb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
